### sv/tlg_pkg.sv
// Shared constants, action codes and controller/datapath types for the life grid.
`timescale 1ns / 1ps

package tlg_pkg;

  // Grid size; edges wrap in both directions
  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLUMNS = 128;

  // Field widths of one beat
  localparam int ACTION_W = 2;
  localparam int ROW_F_W  = 6;
  localparam int COL_F_W  = 7;

  // Index widths that follow from the grid size
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  // Sweep counter runs 0 .. GRID_ROWS+2
  localparam int SEQ_W = $clog2(GRID_ROWS + 3);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             item_ld;    // capture the input beat
    logic             rd_en;      // read one row of the current grid
    logic             rd_item;    // read address is the item's row
    logic [ROW_W-1:0] rd_addr;    // sweep read address
    logic             res_set;    // result takes the addressed cell
    logic             res_clr;    // result is zero
    logic             cell_wr;    // write back the row with one cell changed
    logic             win_shift;  // shift the three-row window
    logic             adv_wr;     // write one row of the new generation
    logic [ROW_W-1:0] adv_addr;   // row written by the sweep
    logic             flip;       // new generation becomes current
    logic             out_ld;     // load the output register
  } tlg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                in_grid;  // row and column lie within the grid
  } tlg_sts_t;

endpackage

### sv/tlg_ifs.sv
// Valid/ready channel interfaces for the item input and the result output.
`timescale 1ns / 1ps

interface tlg_in_if
  import tlg_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ROW_F_W-1:0]  row;
  logic [COL_F_W-1:0]  column;
  logic                cell_value;

  modport source (output valid, action, row, column, cell_value, input ready);
  modport sink   (input valid, action, row, column, cell_value, output ready);
endinterface

interface tlg_out_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, cell_alive, input ready);
  modport sink   (input valid, cell_alive, output ready);
endinterface

### sv/toroidal_life_grid.sv
// Top level of the toroidal life grid: controller plus datapath on two valid/ready channels.
`timescale 1ns / 1ps

// Game of Life on a GRID_ROWS x GRID_COLUMNS torus. Each input beat writes one
// cell, reads one cell or advances one generation, and gives exactly one result
// beat (the cell for an in-grid read, 0 otherwise). One item is worked on at a
// time; the next one is taken while the previous result waits in the output
// register. A write is one read-modify-write on a row-wide memory, a read one
// row read. In an advance, the single read port streams GRID_ROWS + 2 rows
// through a three-row window and one new row is written per cycle into the
// second bank, which then becomes current. The grid is dead after reset through
// per-row valid bits; there is no clearing pass, and the block is ready directly
// after reset.

module toroidal_life_grid
  import tlg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tlg_in_if.sink           in_if,
  tlg_out_if.source        out_if
);

  tlg_cmd_t cmd;
  tlg_sts_t sts;

  tlg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_if.action),
    .in_row         (in_if.row),
    .in_column      (in_if.column),
    .in_cell_value  (in_if.cell_value),
    .out_cell_alive (out_if.cell_alive)
  );

endmodule

### sv/tlg_ctrl.sv
// Controller state machine: sequences cell access, generation sweep and result hand-off.
`timescale 1ns / 1ps

module tlg_ctrl
  import tlg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tlg_sts_t sts,
  output tlg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_ADV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [SEQ_W-1:0] SEQ_LAST_RD = SEQ_W'(GRID_ROWS + 1);
  localparam logic [SEQ_W-1:0] SEQ_END     = SEQ_W'(GRID_ROWS + 2);
  localparam logic [SEQ_W-1:0] SEQ_ROWS    = SEQ_W'(GRID_ROWS);
  localparam logic [SEQ_W-1:0] SEQ_FIRST_W = SEQ_W'(3);

  logic [2:0]       state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if ((sts.action == ACT_WRITE || sts.action == ACT_READ) && sts.in_grid) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_item = 1'b1;
          state_nxt   = S_ACC;
        end else if (sts.action == ACT_ADVANCE) begin
          seq_nxt   = '0;
          state_nxt = S_ADV;
        end else begin
          // out-of-grid access or unused code: no effect, result zero
          cmd.res_clr = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_ACC: begin
        if (sts.action == ACT_READ) begin
          cmd.res_set = 1'b1;
        end else begin
          cmd.cell_wr = 1'b1;
          cmd.res_clr = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_ADV: begin
        // stream rows last, 0 .. last, 0 through the window
        cmd.win_shift = 1'b1;
        if (seq_r <= SEQ_LAST_RD) begin
          cmd.rd_en = 1'b1;
        end
        if (seq_r == '0) begin
          cmd.rd_addr = ROW_W'(GRID_ROWS - 1);
        end else if (seq_r <= SEQ_ROWS) begin
          cmd.rd_addr = ROW_W'(seq_r - SEQ_W'(1));
        end else begin
          cmd.rd_addr = '0;
        end
        // window is full from the fourth step on
        if (seq_r >= SEQ_FIRST_W) begin
          cmd.adv_wr   = 1'b1;
          cmd.adv_addr = ROW_W'(seq_r - SEQ_FIRST_W);
        end
        if (seq_r == SEQ_END) begin
          cmd.flip    = 1'b1;
          cmd.res_clr = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          seq_nxt = seq_r + SEQ_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/tlg_datapath.sv
// Datapath: two row-wide grid banks, row valid bits, three-row window and life rule.
`timescale 1ns / 1ps

module tlg_datapath
  import tlg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tlg_cmd_t            cmd,
  output tlg_sts_t            sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ROW_F_W-1:0]  in_row,
  input  logic [COL_F_W-1:0]  in_column,
  input  logic                in_cell_value,
  output logic                out_cell_alive
);

  localparam logic [3:0] N_SURVIVE = 4'd2;
  localparam logic [3:0] N_BIRTH   = 4'd3;

  // Item registers
  logic [ACTION_W-1:0] act_r;
  logic [ROW_F_W-1:0]  row_r;
  logic [COL_F_W-1:0]  col_r;
  logic                val_r;

  // Grid banks; bank_r selects the current generation
  logic [GRID_COLUMNS-1:0] bank0_mem [GRID_ROWS];
  logic [GRID_COLUMNS-1:0] bank1_mem [GRID_ROWS];
  logic                    bank_r;
  logic [GRID_ROWS-1:0]    valid_r;

  logic [GRID_COLUMNS-1:0] rdata_r;
  logic                    rvalid_r;
  logic [GRID_COLUMNS-1:0] row_q;
  logic [GRID_COLUMNS-1:0] win0_r, win1_r;
  logic [GRID_COLUMNS-1:0] life_row;
  logic [GRID_COLUMNS-1:0] cell_row;
  logic [ROW_W-1:0]        row_idx;
  logic [COL_W-1:0]        col_idx;
  logic [ROW_W-1:0]        rd_addr;
  logic                    wr_en;
  logic                    wr_bank;
  logic [ROW_W-1:0]        wr_addr;
  logic [GRID_COLUMNS-1:0] wr_data;
  logic                    res_r;
  logic                    out_cell_r;

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      act_r <= in_action;
      row_r <= in_row;
      col_r <= in_column;
      val_r <= in_cell_value;
    end
  end

  assign row_idx     = ROW_W'(row_r);
  assign col_idx     = COL_W'(col_r);
  assign sts.action  = act_r;
  assign sts.in_grid = (32'(row_r) < GRID_ROWS) && (32'(col_r) < GRID_COLUMNS);

  // Row read from the current bank; rows never written since reset read as dead
  assign rd_addr = cmd.rd_item ? row_idx : cmd.rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r  <= bank_r ? bank1_mem[rd_addr] : bank0_mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
  end

  assign row_q = rvalid_r ? rdata_r : '0;

  // Single-cell update of the fetched row
  always_comb begin
    cell_row          = row_q;
    cell_row[col_idx] = val_r;
  end

  // Three-row window: win1 above, win0 middle, fetched row below
  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      win1_r <= win0_r;
      win0_r <= row_q;
    end
  end

  // Life rule for every column of the middle row, columns wrap
  always_comb begin
    logic [COL_W-1:0] lj;
    logic [COL_W-1:0] rj;
    logic [3:0]       cnt;
    life_row = '0;
    for (int j = 0; j < GRID_COLUMNS; j++) begin
      lj  = (j == 0) ? COL_W'(GRID_COLUMNS - 1) : COL_W'(j - 1);
      rj  = (j == GRID_COLUMNS - 1) ? COL_W'(0) : COL_W'(j + 1);
      cnt = 4'(win1_r[lj]) + 4'(win1_r[j]) + 4'(win1_r[rj])
          + 4'(win0_r[lj]) + 4'(win0_r[rj])
          + 4'(row_q[lj]) + 4'(row_q[j]) + 4'(row_q[rj]);
      life_row[j] = win0_r[j] ? (cnt == N_SURVIVE || cnt == N_BIRTH) : (cnt == N_BIRTH);
    end
  end

  // Write port: cell writes go to the current bank, the sweep to the other one
  assign wr_en   = cmd.cell_wr | cmd.adv_wr;
  assign wr_bank = cmd.adv_wr ? ~bank_r : bank_r;
  assign wr_addr = cmd.adv_wr ? cmd.adv_addr : row_idx;
  assign wr_data = cmd.adv_wr ? life_row : cell_row;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank0_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      bank1_mem[wr_addr] <= wr_data;
    end
  end

  // Bank select and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      valid_r <= '0;
    end else if (cmd.flip) begin
      // the sweep wrote every row of the new bank
      bank_r  <= ~bank_r;
      valid_r <= '1;
    end else if (cmd.cell_wr) begin
      valid_r[row_idx] <= 1'b1;
    end
  end

  // Result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_r <= row_q[col_idx];
    end else if (cmd.res_clr) begin
      res_r <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_cell_r <= res_r;
    end
  end

  assign out_cell_alive = out_cell_r;

endmodule

### sv/tlg_checker.sv
// Port-level checks on the life grid top level, attached by bind.
`timescale 1ns / 1ps

module tlg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell_alive
);

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // One item at a time: no beat is taken in the cycle after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in the cycle after an accepted beat");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cell_alive))
    else $error("result changed while stalled");

endmodule

bind toroidal_life_grid tlg_checker u_tlg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_cell_alive (out_if.cell_alive)
);
